@@ hdl/websocket_frame_deframer_unmask_unit_defines.svh @@
// assertion macros used by the checker
`ifndef WEBSOCKET_FRAME_DEFRAMER_UNMASK_UNIT_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_UNMASK_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define WSD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define WSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/wsd_pkg.sv @@
// shared types and constants of the websocket deframer
package wsd_pkg;

  // low seven bits of header byte one hold the length code
  localparam logic [7:0] LenCodeMask = 8'h7f;
  // length codes at or above this read a 16-bit extended length
  localparam logic [6:0] LenCodeExt = 7'd126;
  // number of mask-key bytes in every client frame
  localparam logic [15:0] MaskKeyBytes = 16'd4;

  // one classified item handed from the parser to the output stage
  typedef struct packed {
    logic [7:0]  rx_byte;
    logic [7:0]  key_byte;
    logic [7:0]  opcode;
    logic [15:0] length;
    logic        data_valid;
    logic        last;
  } item_t;

endpackage

@@ hdl/wsd_front.sv @@
// header parser: tracks frame phase, collects length and mask key, classifies bytes
module wsd_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [7:0]     rx_byte_i,
  input  logic           frame_start_i,
  input  logic           q_ready_i,
  output logic           q_push_o,
  output wsd_pkg::item_t q_item_o
);

  localparam logic [2:0] PhIdle  = 3'd0;
  localparam logic [2:0] PhLen7  = 3'd1;
  localparam logic [2:0] PhExtHi = 3'd2;
  localparam logic [2:0] PhExtLo = 3'd3;
  localparam logic [2:0] PhMask  = 3'd4;
  localparam logic [2:0] PhData  = 3'd5;

  logic [2:0]  phase_q, phase_d;
  logic [7:0]  opcode_q, opcode_d;
  logic [15:0] length_q, length_d;
  logic [31:0] mask_q, mask_d;
  logic [15:0] count_q, count_d;
  logic        accept;
  logic [6:0]  len_code;
  logic [7:0]  key_byte;
  logic [16:0] count_inc;

  assign in_ready_o = q_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign len_code   = rx_byte_i[6:0] & wsd_pkg::LenCodeMask[6:0];
  assign count_inc  = {1'b0, count_q} + 17'd1;

  // first key byte sits in the top bits
  always_comb begin
    case (count_q[1:0])
      2'd0:    key_byte = mask_q[31:24];
      2'd1:    key_byte = mask_q[23:16];
      2'd2:    key_byte = mask_q[15:8];
      default: key_byte = mask_q[7:0];
    endcase
  end

  always_comb begin
    phase_d  = phase_q;
    opcode_d = opcode_q;
    length_d = length_q;
    mask_d   = mask_q;
    count_d  = count_q;
    q_push_o = 1'b0;
    q_item_o.rx_byte    = rx_byte_i;
    q_item_o.key_byte   = key_byte;
    q_item_o.opcode     = opcode_q;
    q_item_o.length     = length_q;
    q_item_o.data_valid = 1'b1;
    q_item_o.last       = 1'b0;
    if (accept) begin
      if (frame_start_i) begin
        opcode_d = rx_byte_i;
        length_d = '0;
        mask_d   = '0;
        count_d  = '0;
        phase_d  = PhLen7;
      end else begin
        unique case (phase_q)
          PhLen7: begin
            if (len_code < wsd_pkg::LenCodeExt) begin
              length_d = {9'd0, len_code};
              count_d  = '0;
              phase_d  = PhMask;
            end else begin
              phase_d = PhExtHi;
            end
          end
          PhExtHi: begin
            length_d = {rx_byte_i, 8'd0};
            phase_d  = PhExtLo;
          end
          PhExtLo: begin
            length_d = {length_q[15:8], rx_byte_i};
            count_d  = '0;
            phase_d  = PhMask;
          end
          PhMask: begin
            mask_d  = {mask_q[23:0], rx_byte_i};
            count_d = count_inc[15:0];
            if (count_inc[15:0] >= wsd_pkg::MaskKeyBytes) begin
              count_d = '0;
              if (length_q == 16'd0) begin
                // empty frame: header-only result
                q_push_o            = 1'b1;
                q_item_o.data_valid = 1'b0;
                q_item_o.last       = 1'b1;
                phase_d             = PhIdle;
              end else begin
                phase_d = PhData;
              end
            end
          end
          PhData: begin
            count_d  = count_inc[15:0];
            q_push_o = 1'b1;
            if (count_inc >= {1'b0, length_q}) begin
              q_item_o.last = 1'b1;
              phase_d       = PhIdle;
            end
          end
          default: begin
            opcode_d = rx_byte_i;
            length_d = '0;
            mask_d   = '0;
            count_d  = '0;
            phase_d  = PhLen7;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhIdle;
      opcode_q <= '0;
      length_q <= '0;
      mask_q   <= '0;
      count_q  <= '0;
    end else begin
      phase_q  <= phase_d;
      opcode_q <= opcode_d;
      length_q <= length_d;
      mask_q   <= mask_d;
      count_q  <= count_d;
    end
  end

endmodule

@@ hdl/wsd_fifo.sv @@
// small register queue between the parser and the output stage
module wsd_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  wsd_pkg::item_t item_i,
  output logic           ready_o,
  input  logic           pop_i,
  output logic           valid_o,
  output wsd_pkg::item_t item_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  wsd_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign ready_o = (count_q != FullCnt);
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

@@ hdl/wsd_back.sv @@
// output stage: unmasks payload bytes into the result register
module wsd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  wsd_pkg::item_t q_item_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     payload_byte_o,
  output logic           payload_valid_o,
  output logic [7:0]     frame_opcode_o,
  output logic [15:0]    frame_length_o,
  output logic           last_o
);

  logic        valid_q;
  logic [7:0]  byte_q, byte_d;
  logic        pvalid_q;
  logic [7:0]  opcode_q;
  logic [15:0] length_q;
  logic        last_q;

  assign q_pop_o = q_valid_i && (!valid_q || out_ready_i);
  // header-only results carry a zero byte
  assign byte_d  = q_item_i.data_valid ? (q_item_i.rx_byte ^ q_item_i.key_byte) : 8'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || out_ready_i) begin
      valid_q <= q_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      byte_q   <= byte_d;
      pvalid_q <= q_item_i.data_valid;
      opcode_q <= q_item_i.opcode;
      length_q <= q_item_i.length;
      last_q   <= q_item_i.last;
    end
  end

  assign out_valid_o     = valid_q;
  assign payload_byte_o  = byte_q;
  assign payload_valid_o = pvalid_q;
  assign frame_opcode_o  = opcode_q;
  assign frame_length_o  = length_q;
  assign last_o          = last_q;

endmodule

@@ hdl/websocket_frame_deframer_unmask_unit.sv @@
// top level of the websocket frame deframer and unmasker
// throughput: one byte transfer per cycle in steady state, while the queue has room
// a payload byte passes from its input transfer into a queue entry and then into the output
//   register, where it is presented and from which it can leave on its output transfer
// header and mask-key bytes produce no result; an empty frame yields one header-only result
// reset: asynchronous active-low, parser returns to idle, queue and output register empty
module websocket_frame_deframer_unmask_unit #(
  // queue depth between parser and output stage, at least 2
  parameter int unsigned FifoDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input byte stream
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        frame_start_i,
  // result stream
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  payload_byte_o,
  output logic        payload_valid_o,
  output logic [7:0]  frame_opcode_o,
  output logic [15:0] frame_length_o,
  output logic        last_o
);

  // parser to queue
  logic           push;
  wsd_pkg::item_t push_item;
  logic           q_ready;
  // queue to output stage
  logic           q_valid;
  logic           pop;
  wsd_pkg::item_t pop_item;

  // front: walks the header and classifies every byte transfer;
  // it stalls only when the queue is full
  wsd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .rx_byte_i     (rx_byte_i),
    .frame_start_i (frame_start_i),
    .q_ready_i     (q_ready),
    .q_push_o      (push),
    .q_item_o      (push_item)
  );

  // decoupling queue, lets the output side stall without losing bytes
  wsd_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .ready_o (q_ready),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (pop_item)
  );

  // back: xor with the selected key byte and hold the result until its transfer
  wsd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_item_i        (pop_item),
    .q_pop_o         (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .payload_byte_o  (payload_byte_o),
    .payload_valid_o (payload_valid_o),
    .frame_opcode_o  (frame_opcode_o),
    .frame_length_o  (frame_length_o),
    .last_o          (last_o)
  );

endmodule

@@ hdl/wsd_checker.sv @@
// port-level checker for the deframer, bound to the top level
`include "websocket_frame_deframer_unmask_unit_defines.svh"

module wsd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [7:0]  rx_byte_i,
  input logic        frame_start_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  payload_byte_o,
  input logic        payload_valid_o,
  input logic [7:0]  frame_opcode_o,
  input logic [15:0] frame_length_o,
  input logic        last_o
);

  logic stalled;
  logic in_stalled;
  logic header_only;

  assign stalled     = out_valid_o && !out_ready_i;
  assign in_stalled  = in_valid_i && !in_ready_o;
  assign header_only = out_valid_o && !payload_valid_o;

  // a waiting input byte stays up with its payload
  `WSD_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_stalled, in_valid_i && $stable(rx_byte_i) && $stable(frame_start_i), "input changed while waiting")
  // a stalled result stays up
  `WSD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, stalled, out_valid_o, "result dropped while stalled")
  // a stalled result keeps its payload
  `WSD_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, stalled, $stable(payload_byte_o) && $stable(payload_valid_o) && $stable(frame_opcode_o) && $stable(frame_length_o) && $stable(last_o), "result changed while stalled")
  // header-only result ends its frame and carries a zero byte
  `WSD_ASSERT_NOW(a_hdr_only_last, clk_i, rst_ni, header_only, last_o && (payload_byte_o == 8'd0), "header-only result not final or nonzero")
  // header-only result only for an empty frame
  `WSD_ASSERT_NOW(a_hdr_only_len, clk_i, rst_ni, header_only, frame_length_o == 16'd0, "header-only result with nonzero length")

endmodule

bind websocket_frame_deframer_unmask_unit wsd_checker u_wsd_checker (.*);

@@ sim/websocket_frame_deframer_unmask_unit_tb.sv @@
// self-checking testbench for the websocket frame deframer and unmasker
`timescale 1ns / 100ps

module websocket_frame_deframer_unmask_unit_tb;

  // run length and watchdog
  localparam int unsigned RandItems = 500;
  localparam int unsigned LimitCycles = 200000;
  localparam int unsigned TailCycles = 8;
  localparam int unsigned MaxPrinted = 50;

  // header decode constants
  localparam logic [6:0] CodeExtLen = 7'd126;
  localparam logic [15:0] KeyBytes = 16'd4;

  // parser phases of the frame decoder
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEN,
    ST_EXT_HI,
    ST_EXT_LO,
    ST_MASK,
    ST_DATA
  } parse_phase_e;

  // one output transfer
  typedef struct packed {
    logic [7:0]  payload;
    logic        data_valid;
    logic [7:0]  opcode;
    logic [15:0] length;
    logic        last;
  } frame_res_t;

  // rows either rely on the frame decoder model or carry a typed result
  typedef enum logic [0:0] {
    ROW_PREDICT,
    ROW_TYPED
  } row_kind_e;

  typedef struct packed {
    logic [7:0] rx;
    logic       start;
    row_kind_e  kind;
    frame_res_t res;
  } byte_row_t;

  localparam frame_res_t NoRes = '0;
  localparam int unsigned DirRows = 27;

  // directed bytes: empty frame, code 127, code 126 at max length, restart
  localparam byte_row_t DirTable [0:DirRows-1] = '{
    // empty ping frame, mask bit clear, all-zero key
    '{8'h89, 1'b0, ROW_PREDICT, NoRes},
    '{8'h00, 1'b0, ROW_PREDICT, NoRes},
    '{8'h00, 1'b0, ROW_PREDICT, NoRes},
    '{8'h00, 1'b0, ROW_PREDICT, NoRes},
    '{8'h00, 1'b0, ROW_PREDICT, NoRes},
    '{8'h00, 1'b0, ROW_TYPED,   '{8'h00, 1'b0, 8'h89, 16'h0000, 1'b1}},
    // code 127 takes two length bytes, one payload byte, all-ones data and first key byte
    '{8'h02, 1'b0, ROW_PREDICT, NoRes},
    '{8'hff, 1'b0, ROW_PREDICT, NoRes},
    '{8'h00, 1'b0, ROW_PREDICT, NoRes},
    '{8'h01, 1'b0, ROW_PREDICT, NoRes},
    '{8'hff, 1'b0, ROW_PREDICT, NoRes},
    '{8'h00, 1'b0, ROW_PREDICT, NoRes},
    '{8'h5a, 1'b0, ROW_PREDICT, NoRes},
    '{8'ha5, 1'b0, ROW_PREDICT, NoRes},
    '{8'hff, 1'b0, ROW_TYPED,   '{8'h00, 1'b1, 8'h02, 16'h0001, 1'b1}},
    // code 126 with maximum length, cut off halfway through the key
    '{8'h0f, 1'b1, ROW_PREDICT, NoRes},
    '{8'h7e, 1'b0, ROW_PREDICT, NoRes},
    '{8'hff, 1'b0, ROW_PREDICT, NoRes},
    '{8'hff, 1'b0, ROW_PREDICT, NoRes},
    '{8'h12, 1'b0, ROW_PREDICT, NoRes},
    '{8'h34, 1'b0, ROW_PREDICT, NoRes},
    // restart mid-key, then an empty close frame
    '{8'h88, 1'b1, ROW_PREDICT, NoRes},
    '{8'h80, 1'b0, ROW_PREDICT, NoRes},
    '{8'hff, 1'b0, ROW_PREDICT, NoRes},
    '{8'hff, 1'b0, ROW_PREDICT, NoRes},
    '{8'hff, 1'b0, ROW_PREDICT, NoRes},
    '{8'hff, 1'b0, ROW_TYPED,   '{8'h00, 1'b0, 8'h88, 16'h0000, 1'b1}}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte = 8'h00;
  logic        frame_start = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  payload_byte;
  logic        payload_valid;
  logic [7:0]  frame_opcode;
  logic [15:0] frame_length;
  logic        last;

  // model state of the frame decoder
  parse_phase_e model_phase = ST_IDLE;
  logic [7:0]   model_opcode = '0;
  logic [15:0]  model_length = '0;
  logic [31:0]  model_key = '0;
  logic [15:0]  model_count = '0;

  byte_row_t   rx_stream[$];
  frame_res_t  pending_res[$];
  int unsigned bytes_taken = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned seg_len = 1;

  websocket_frame_deframer_unmask_unit u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .rx_byte_i       (rx_byte),
    .frame_start_i   (frame_start),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .payload_byte_o  (payload_byte),
    .payload_valid_o (payload_valid),
    .frame_opcode_o  (frame_opcode),
    .frame_length_o  (frame_length),
    .last_o          (last)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
  end

  // advance the frame decoder by one byte, returns 1 when a result comes out
  function automatic bit deframe_byte(input logic [7:0] b, input logic st,
                                      output frame_res_t r);
    logic [7:0] key_byte;
    r = '0;
    // a start flag or an idle parser takes the byte as header byte zero
    if (st || model_phase == ST_IDLE) begin
      model_opcode = b;
      model_length = '0;
      model_key = '0;
      model_count = '0;
      model_phase = ST_LEN;
      return 1'b0;
    end
    case (model_phase)
      ST_LEN: begin
        // mask bit is ignored, 126 and 127 both read two length bytes
        if (b[6:0] < CodeExtLen) begin
          model_length = {9'd0, b[6:0]};
          model_count = '0;
          model_phase = ST_MASK;
        end else begin
          model_phase = ST_EXT_HI;
        end
        return 1'b0;
      end
      ST_EXT_HI: begin
        model_length = {b, 8'h00};
        model_phase = ST_EXT_LO;
        return 1'b0;
      end
      ST_EXT_LO: begin
        model_length[7:0] = b;
        model_count = '0;
        model_phase = ST_MASK;
        return 1'b0;
      end
      ST_MASK: begin
        model_key = {model_key[23:0], b};
        model_count = model_count + 16'd1;
        if (model_count < KeyBytes) return 1'b0;
        model_count = '0;
        // zero-length frame ends with a header-only result
        if (model_length == 16'd0) begin
          model_phase = ST_IDLE;
          r = '{8'h00, 1'b0, model_opcode, model_length, 1'b1};
          return 1'b1;
        end
        model_phase = ST_DATA;
        return 1'b0;
      end
      default: begin
        // first key byte sits in the top byte of the key word
        key_byte = 8'(model_key >> (24 - 8 * model_count[1:0]));
        model_count = model_count + 16'd1;
        r = '{b ^ key_byte, 1'b1, model_opcode, model_length, 1'b0};
        if (model_count >= model_length) begin
          model_phase = ST_IDLE;
          r.last = 1'b1;
        end
        return 1'b1;
      end
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < MaxPrinted) $display("mismatch: %s", msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                results_seen, name, got, want));
    end
  endtask

  // idle percentage per side: sender-heavy, receiver-heavy, then none
  function automatic int unsigned idle_pct(input bit sender_side);
    if (bytes_taken < seg_len) return sender_side ? 38 : 65;
    if (bytes_taken < 2 * seg_len) return sender_side ? 65 : 38;
    return 0;
  endfunction

  function automatic void push_byte(input logic [7:0] b, input logic st);
    byte_row_t row;
    row = '{b, st, ROW_PREDICT, NoRes};
    rx_stream.push_back(row);
  endfunction

  // one random frame, possibly oversized or cut short; returns 1 if oversized or cut short
  function automatic bit push_frame(input bit force_start);
    logic [7:0]  frame_bytes[$];
    logic [15:0] len;
    logic        mbit;
    int unsigned form;
    int unsigned n_data;
    int unsigned cut;
    bit          broken;
    form = $urandom_range(0, 99);
    mbit = 1'($urandom_range(0, 1));
    broken = 1'b0;
    frame_bytes.push_back(8'($urandom_range(0, 255)));
    if (form < 60) begin
      // short length code, now and then a long one
      len = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 125))
                                         : 16'($urandom_range(0, 12));
      frame_bytes.push_back({mbit, len[6:0]});
    end else begin
      // extended length, mostly small, sometimes any 16-bit value
      len = (form < 88) ? 16'($urandom_range(0, 20)) : 16'($urandom_range(0, 65535));
      frame_bytes.push_back({mbit, ($urandom_range(0, 1) != 0) ? 7'd127 : CodeExtLen});
      frame_bytes.push_back(len[15:8]);
      frame_bytes.push_back(len[7:0]);
    end
    repeat (4) frame_bytes.push_back(8'($urandom_range(0, 255)));
    // large frames are always abandoned after a few payload bytes
    n_data = (len > 16'd125) ? $urandom_range(1, 6) : len;
    if (len > 16'd125) broken = 1'b1;
    repeat (n_data) frame_bytes.push_back(8'($urandom_range(0, 255)));
    cut = frame_bytes.size();
    if ($urandom_range(0, 99) < 8) begin
      cut = $urandom_range(1, frame_bytes.size() - 1);
      broken = 1'b1;
    end
    for (int unsigned i = 0; i < cut; i++) begin
      push_byte(frame_bytes[i], (i == 0) ? (force_start | 1'($urandom_range(0, 1))) : 1'b0);
    end
    return broken;
  endfunction

  // input and output side of the handshakes, all driven at the rising edge
  always @(posedge clk) begin
    frame_res_t model_res;
    frame_res_t want;
    bit         has_res;
    if (!rst_n) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      // input transfer: the model runs on each accepted byte
      if (in_valid && in_ready) begin
        has_res = deframe_byte(rx_byte, frame_start, model_res);
        if (rx_stream[bytes_taken].kind == ROW_TYPED) begin
          pending_res.push_back(rx_stream[bytes_taken].res);
        end else if (has_res) begin
          pending_res.push_back(model_res);
        end
        bytes_taken++;
      end
      // present the next byte unless the current one is still waiting
      if (!in_valid || in_ready) begin
        if (bytes_taken < rx_stream.size() && $urandom_range(0, 99) >= idle_pct(1'b1)) begin
          in_valid <= 1'b1;
          rx_byte <= rx_stream[bytes_taken].rx;
          frame_start <= rx_stream[bytes_taken].start;
        end else begin
          in_valid <= 1'b0;
        end
      end
      // output transfer: compare with the oldest pending result
      if (out_valid && out_ready) begin
        if (pending_res.size() == 0) begin
          report_mismatch($sformatf("result %0d with nothing pending", results_seen));
        end else begin
          want = pending_res.pop_front();
          check_field("payload_byte", 16'(payload_byte), 16'(want.payload));
          check_field("payload_valid", 16'(payload_valid), 16'(want.data_valid));
          check_field("frame_opcode", 16'(frame_opcode), 16'(want.opcode));
          check_field("frame_length", frame_length, want.length);
          check_field("last", 16'(last), 16'(want.last));
        end
        results_seen++;
      end
      out_ready <= ($urandom_range(0, 99) >= idle_pct(1'b0));
    end
  end

  // watchdog
  initial begin
    while (cycles < LimitCycles) @(posedge clk);
    $display("FAIL websocket_frame_deframer_unmask_unit");
    $finish;
  end

  initial begin
    bit need_start;
    int unsigned pick;
    foreach (DirTable[i]) rx_stream.push_back(DirTable[i]);
    // random part: mostly whole frames, some noise and broken frames
    need_start = 1'b1;
    while (rx_stream.size() < DirRows + RandItems) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        need_start = 1'b1;
      end else begin
        // after a broken frame, sometimes let the next one be misparsed
        need_start = push_frame(need_start && ($urandom_range(0, 3) != 0));
      end
    end
    seg_len = rx_stream.size() / 3;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    wait (bytes_taken == rx_stream.size());
    while (pending_res.size() != 0) @(posedge clk);
    // any stray result after the last expected one is caught here
    repeat (TailCycles) @(posedge clk);
    if (pending_res.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_res.size()));
    end
    if (mismatches == 0) begin
      $display("PASS websocket_frame_deframer_unmask_unit");
    end else begin
      $display("FAIL websocket_frame_deframer_unmask_unit");
    end
    $finish;
  end

endmodule
